// ===== design/dmkt_pkg.sv =====
package dmkt_pkg;

  // Field widths of the transaction payloads
  localparam int MODE_W       = 3;
  localparam int KEY_W        = 32;
  localparam int IO_VALUE_W   = 32;
  localparam int SLOT_FIELD_W = 10;
  localparam int ENTRIES_W    = 11;

  // Default table geometry
  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_VALUE_WIDTH = 32;

  // Key reduction: key bits folded into the remainder per cycle
  localparam int HASH_RADIX_BITS = 4;
  localparam int HASH_STEPS      = KEY_W / HASH_RADIX_BITS;
  localparam int HCNT_W          = $clog2(HASH_STEPS + 1);

  typedef enum logic [MODE_W-1:0] {
    OP_ADD        = 3'd0,
    OP_REMOVE     = 3'd1,
    OP_HAS_KEY    = 3'd2,
    OP_HAS_VALUE  = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_SCAN_START = 3'd5,
    OP_SCAN_NEXT  = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_HASH,
    S_WALK,
    S_CLEAR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic signed [KEY_W-1:0] key;
    logic [IO_VALUE_W-1:0]   value;
  } dmkt_req_t;

  typedef struct packed {
    logic                    ok;
    logic [IO_VALUE_W-1:0]   found_value;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [ENTRIES_W-1:0]    entries;
  } dmkt_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic hash;
    logic read_idx;
    logic walk;
    logic clear;
    logic finish;
  } dmkt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  in_mode;
    logic in_value_nz;
    logic hash_done;
    logic walk_done;
    logic clr_done;
    logic out_free;
  } dmkt_stat_t;

endpackage

// ===== design/dmkt_if.sv =====
interface dmkt_req_if;
  import dmkt_pkg::*;

  logic      valid;
  logic      ready;
  dmkt_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dmkt_rsp_if;
  import dmkt_pkg::*;

  logic      valid;
  logic      ready;
  dmkt_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/dmkt_ram.sv =====
module dmkt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/dmkt_ctrl.sv =====
module dmkt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dmkt_pkg::dmkt_stat_t stat,
  output dmkt_pkg::dmkt_cmd_t  cmd
);
  import dmkt_pkg::*;

  state_t state;
  state_t state_next;

  // State register; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (stat.in_mode) inside
            OP_ADD, OP_REMOVE, OP_HAS_KEY: state_next = S_HASH;
            OP_HAS_VALUE: state_next = stat.in_value_nz ? S_WALK : S_FINISH;
            OP_CLEAR:     state_next = S_CLEAR;
            OP_SCAN_NEXT: state_next = S_WALK;
            default:      state_next = S_FINISH;
          endcase
        end
      end
      S_HASH: begin
        if (stat.hash_done) state_next = S_FINISH;
      end
      S_WALK: begin
        if (stat.walk_done) state_next = S_FINISH;
      end
      S_CLEAR: begin
        if (stat.clr_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  // Commands
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state)
      S_INIT: begin
        cmd.clear = !stat.clr_done;
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_HASH: begin
        cmd.hash     = !stat.hash_done;
        cmd.read_idx = stat.hash_done;
      end
      S_WALK: begin
        cmd.walk = !stat.walk_done;
      end
      S_CLEAR: begin
        cmd.clear = !stat.clr_done;
      end
      S_FINISH: begin
        cmd.finish = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // A result is never written over one that is still waiting
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> stat.out_free)
    else $error("result written while output register busy");

  // Walking and clearing never share the memory ports
  a_walk_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !cmd.walk && !cmd.read_idx && !cmd.finish)
    else $error("clear overlaps another memory access");

  // Capture only on an accepted transaction
  a_capture_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (in_valid && in_ready))
    else $error("capture without an accepted transaction");
`endif

endmodule

// ===== design/dmkt_datapath.sv =====
module dmkt_datapath #(
  parameter int TABLE_DEPTH = dmkt_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = dmkt_pkg::DEF_VALUE_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dmkt_pkg::dmkt_cmd_t  cmd,
  output dmkt_pkg::dmkt_stat_t stat,
  input  dmkt_pkg::dmkt_req_t  in_data,
  output dmkt_pkg::dmkt_rsp_t  out_data,
  output logic                 out_valid,
  input  logic                 out_ready
);
  import dmkt_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam logic [SLOT_W:0]    DEPTH_S   = (SLOT_W + 1)'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0]   DEPTH_C   = CNT_W'(TABLE_DEPTH);
  localparam logic [63:0]        WRAP_FULL = (64'd1 << KEY_W) % TABLE_DEPTH;
  localparam logic [SLOT_W:0]    WRAP      = WRAP_FULL[SLOT_W:0];

  // Captured transaction
  op_t                    op;
  logic [KEY_W-1:0]       key_sr;
  logic                   key_neg;
  logic [VALUE_WIDTH-1:0] val_m;
  logic                   val_nz;

  // Key reduction
  logic [SLOT_W-1:0] rem;
  logic [SLOT_W-1:0] rem_acc;
  logic [SLOT_W-1:0] rem_step;
  logic [SLOT_W:0]   trial;
  logic [SLOT_W:0]   idx_ext;
  logic [SLOT_W-1:0] idx;
  logic [HCNT_W-1:0] hcnt;

  // Walk pipeline
  logic [CNT_W-1:0]       ptr;
  logic                   pv;
  logic [SLOT_W-1:0]      paddr;
  logic                   hit;
  logic [SLOT_W-1:0]      hit_addr;
  logic [VALUE_WIDTH-1:0] hit_data;
  logic                   match_now;
  logic                   walk_issue;

  // Clear sweep and table state
  logic [CNT_W-1:0] clr_ptr;
  logic             clr_we;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] cursor;
  logic [CNT_W-1:0] cursor_next;

  // Memory ports
  logic                   rd_en;
  logic [SLOT_W-1:0]      rd_addr;
  logic [VALUE_WIDTH-1:0] rd_data;
  logic                   wr_en;
  logic [SLOT_W-1:0]      wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;

  // Result of the finishing cycle
  logic                   res_ok;
  logic [VALUE_WIDTH-1:0] res_fv;
  logic [SLOT_W-1:0]      res_slot;
  logic                   res_we;
  logic [VALUE_WIDTH-1:0] res_wdata;

  assign val_nz = |val_m;

  // Fold the next key bits into the remainder, one compare and subtract each
  always_comb begin
    rem_acc = rem;
    trial   = '0;
    for (int j = 0; j < HASH_RADIX_BITS; j++) begin
      trial = {rem_acc, key_sr[KEY_W-1-j]};
      if (trial >= DEPTH_S) trial = trial - DEPTH_S;
      rem_acc = trial[SLOT_W-1:0];
    end
    rem_step = rem_acc;
  end

  // Floor the remainder of a negative key
  always_comb begin
    if (!key_neg) begin
      idx_ext = {1'b0, rem};
    end else if ({1'b0, rem} >= WRAP) begin
      idx_ext = {1'b0, rem} - WRAP;
    end else begin
      idx_ext = {1'b0, rem} + DEPTH_S - WRAP;
    end
  end
  assign idx = idx_ext[SLOT_W-1:0];

  // Walk match: a value search compares, a scan looks for any occupied slot
  always_comb begin
    if (op == OP_HAS_VALUE) begin
      match_now = pv && (rd_data == val_m);
    end else begin
      match_now = pv && (rd_data != '0);
    end
  end

  assign walk_issue = cmd.walk && !hit && !match_now && (ptr != DEPTH_C);
  assign clr_we     = cmd.clear && (clr_ptr != DEPTH_C);

  // Memory port selection
  assign rd_en   = cmd.read_idx || walk_issue;
  assign rd_addr = cmd.read_idx ? idx : ptr[SLOT_W-1:0];
  assign wr_en   = clr_we || (cmd.finish && res_we);
  assign wr_addr = clr_we ? clr_ptr[SLOT_W-1:0] : idx;
  assign wr_data = clr_we ? '0 : res_wdata;

  dmkt_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Decide the result of the transaction
  always_comb begin
    res_ok      = 1'b0;
    res_fv      = '0;
    res_slot    = '0;
    res_we      = 1'b0;
    res_wdata   = '0;
    count_next  = count;
    cursor_next = cursor;
    case (op)
      OP_ADD: begin
        res_slot  = idx;
        res_ok    = val_nz && (rd_data == '0);
        res_we    = res_ok;
        res_wdata = val_m;
        if (res_ok) count_next = count + 1'b1;
      end
      OP_REMOVE: begin
        res_slot = idx;
        res_ok   = (rd_data != '0);
        res_we   = res_ok;
        if (res_ok && count != '0) count_next = count - 1'b1;
      end
      OP_HAS_KEY: begin
        res_slot = idx;
        res_ok   = (rd_data != '0);
      end
      OP_HAS_VALUE: begin
        res_ok   = hit;
        res_slot = hit ? hit_addr : '0;
      end
      OP_CLEAR: begin
        res_ok     = 1'b1;
        count_next = '0;
      end
      OP_SCAN_START: begin
        res_ok      = 1'b1;
        cursor_next = '0;
      end
      OP_SCAN_NEXT: begin
        res_ok = hit;
        if (hit) begin
          res_slot    = hit_addr;
          res_fv      = hit_data;
          cursor_next = CNT_W'(hit_addr) + 1'b1;
        end else begin
          cursor_next = DEPTH_C;
        end
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  // Capture the transaction and reduce the key
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op      <= op_t'(in_data.mode);
      key_sr  <= in_data.key;
      key_neg <= in_data.key[KEY_W-1];
      val_m   <= VALUE_WIDTH'(in_data.value);
      rem     <= '0;
      hcnt    <= '0;
    end else if (cmd.hash) begin
      key_sr <= key_sr << HASH_RADIX_BITS;
      rem    <= rem_step;
      hcnt   <= hcnt + 1'b1;
    end
  end

  // Advance the walk; stop at the first match
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      pv  <= 1'b0;
      hit <= 1'b0;
    end else if (cmd.capture) begin
      ptr <= (op_t'(in_data.mode) == OP_SCAN_NEXT) ? cursor : '0;
      pv  <= 1'b0;
      hit <= 1'b0;
    end else if (cmd.walk && !hit) begin
      if (match_now) begin
        hit      <= 1'b1;
        hit_addr <= paddr;
        hit_data <= rd_data;
        pv       <= 1'b0;
      end else if (walk_issue) begin
        paddr <= ptr[SLOT_W-1:0];
        pv    <= 1'b1;
        ptr   <= ptr + 1'b1;
      end else begin
        pv <= 1'b0;
      end
    end
  end

  // Clear sweep pointer; reset starts the sweep at slot zero
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (cmd.capture) begin
      clr_ptr <= '0;
    end else if (clr_we) begin
      clr_ptr <= clr_ptr + 1'b1;
    end
  end

  // Entry count, scan cursor and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cursor    <= DEPTH_C;
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      count     <= count_next;
      cursor    <= cursor_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.ok          <= res_ok;
      out_data.found_value <= IO_VALUE_W'(res_fv);
      out_data.slot        <= SLOT_FIELD_W'(res_slot);
      out_data.entries     <= ENTRIES_W'(count_next);
    end
  end

  // Status to the controller
  assign stat.in_mode     = op_t'(in_data.mode);
  assign stat.in_value_nz = |VALUE_WIDTH'(in_data.value);
  assign stat.hash_done   = (hcnt == HCNT_W'(HASH_STEPS));
  assign stat.walk_done   = hit || (!pv && (ptr == DEPTH_C));
  assign stat.clr_done    = (clr_ptr == DEPTH_C);
  assign stat.out_free    = !out_valid || out_ready;

`ifndef ASSERT_OFF
  // The count never exceeds the number of slots
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count beyond table depth");

  // A successful add raises the count by one
  a_add_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && op == OP_ADD && res_ok) |=> (count == $past(count) + 1'b1))
    else $error("add did not increment entry count");

  // The walk never reports an empty slot
  a_hit_nonzero: assert property (@(posedge clk) disable iff (rst)
    $rose(hit) |-> (hit_data != '0))
    else $error("walk stopped at an empty slot");
`endif

endmodule

// ===== design/direct_mapped_key_table_core.sv =====
// Direct-mapped key table: a signed key selects slot (key floored mod TABLE_DEPTH), each
// slot holds one nonzero value, zero marks empty. Every request transaction returns one
// response transaction. After reset the block sweeps the table to zero and accepts no
// request until the sweep ends. Steps per request, from acceptance to a result in the
// output register: scan start and the unused mode go straight to the result; add, remove
// and key test run the key reduction (4 key bits per cycle through a compare-and-subtract
// chain), then one registered memory read and one update; value search and scan next walk
// the slots, one memory read per cycle through the single read port; clear writes one slot
// per cycle. A value search for zero skips the walk. The output register lets the next
// request be accepted while a response waits to be taken.
module direct_mapped_key_table_core #(
  parameter int TABLE_DEPTH = dmkt_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = dmkt_pkg::DEF_VALUE_WIDTH
) (
  input logic        clk,
  input logic        rst,
  dmkt_req_if.sink   req,
  dmkt_rsp_if.source rsp
);
  import dmkt_pkg::*;

  dmkt_cmd_t  cmd;
  dmkt_stat_t stat;

  dmkt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dmkt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (req.data),
    .out_data  (rsp.data),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready)
  );

endmodule

// ===== dv/tb.sv =====
module tb;
  import dmkt_pkg::*;

  localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
  localparam int VALUE_WIDTH = DEF_VALUE_WIDTH;
  localparam logic [IO_VALUE_W-1:0] VALUE_MASK = (VALUE_WIDTH >= IO_VALUE_W) ? '1 :
                                                 IO_VALUE_W'((64'd1 << VALUE_WIDTH) - 1);
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS   = 830;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES   = TABLE_DEPTH + 64;

  // Shadow copy of the table; predicts one response per request transaction
  class key_table_scoreboard;
    logic [IO_VALUE_W-1:0] slot_mem [TABLE_DEPTH];
    int unsigned occupied;
    int unsigned cursor;
    bit          scanning;
    dmkt_rsp_t   expected_rsp_q [$];
    int unsigned mismatches;

    function new();
      foreach (slot_mem[i]) slot_mem[i] = '0;
      occupied   = 0;
      cursor     = TABLE_DEPTH;
      scanning   = 1'b0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_rsp_q.size();
    endfunction

    function void flag_error(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Apply one accepted request to the shadow table and queue its response
    function void note_request(dmkt_req_t r);
      dmkt_rsp_t             want;
      logic [IO_VALUE_W-1:0] v;
      longint                k;
      int unsigned           idx;
      int unsigned           i;
      want = '0;
      v    = r.value & VALUE_MASK;
      // floored remainder keeps negative keys inside the table
      k = longint'($signed(r.key)) % TABLE_DEPTH;
      if (k < 0) k += TABLE_DEPTH;
      idx = int'(k);
      case (r.mode)
        OP_ADD: begin
          want.slot = SLOT_FIELD_W'(idx);
          if (v != '0 && slot_mem[idx] == '0) begin
            slot_mem[idx] = v;
            occupied++;
            want.ok = 1'b1;
          end
        end
        OP_REMOVE: begin
          want.slot = SLOT_FIELD_W'(idx);
          if (slot_mem[idx] != '0) begin
            slot_mem[idx] = '0;
            if (occupied > 0) occupied--;
            want.ok = 1'b1;
          end
        end
        OP_HAS_KEY: begin
          want.slot = SLOT_FIELD_W'(idx);
          want.ok   = (slot_mem[idx] != '0);
        end
        OP_HAS_VALUE: begin
          // zero is never stored, so searching for it never hits
          if (v != '0) begin
            for (i = 0; i < TABLE_DEPTH; i++) begin
              if (slot_mem[i] == v) begin
                want.ok   = 1'b1;
                want.slot = SLOT_FIELD_W'(i);
                break;
              end
            end
          end
        end
        OP_CLEAR: begin
          foreach (slot_mem[j]) slot_mem[j] = '0;
          occupied = 0;
          want.ok  = 1'b1;
        end
        OP_SCAN_START: begin
          cursor   = 0;
          scanning = 1'b1;
          want.ok  = 1'b1;
        end
        OP_SCAN_NEXT: begin
          i = cursor;
          while (i < TABLE_DEPTH && slot_mem[i] == '0) i++;
          if (i < TABLE_DEPTH) begin
            want.ok          = 1'b1;
            want.slot        = SLOT_FIELD_W'(i);
            want.found_value = slot_mem[i];
            cursor           = i + 1;
          end else begin
            cursor   = TABLE_DEPTH;
            scanning = 1'b0;
          end
        end
        default: ;
      endcase
      want.entries = ENTRIES_W'(occupied);
      expected_rsp_q.push_back(want);
    endfunction

    // Compare one accepted response with the oldest prediction
    function void check_response(dmkt_rsp_t got);
      dmkt_rsp_t want;
      if (expected_rsp_q.size() == 0) begin
        flag_error($sformatf("response with none pending: ok=%0b value=%h slot=%0d entries=%0d",
                             got.ok, got.found_value, got.slot, got.entries));
        return;
      end
      want = expected_rsp_q.pop_front();
      if (got.ok !== want.ok || got.found_value !== want.found_value ||
          got.slot !== want.slot || got.entries !== want.entries)
        flag_error($sformatf("want ok=%0b value=%h slot=%0d entries=%0d, got ok=%0b value=%h slot=%0d entries=%0d",
                             want.ok, want.found_value, want.slot, want.entries,
                             got.ok, got.found_value, got.slot, got.entries));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  dmkt_req_if req_if ();
  dmkt_rsp_if rsp_if ();

  direct_mapped_key_table_core #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  key_table_scoreboard   sb;
  int                    tx_idle_pct;
  int                    rx_idle_pct;
  int                    rx_hold_seq;
  logic [IO_VALUE_W-1:0] value_pool [16];

  always #10 clk = ~clk;

  // Give up after a generous fixed time
  initial begin
    #(20 * 6_000_000);
    $display("FAILED: results differ");
    $finish;
  end

  // Observe both channels at the clock edge
  always @(posedge clk) begin
    if (!rst) begin
      if (req_if.valid && req_if.ready) sb.note_request(req_if.data);
      if (rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
    end
  end

  // Drive response ready: random idling, plus a long hold-off on request
  initial begin
    int seen_holds;
    seen_holds = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_seq != seen_holds) begin
        seen_holds = rx_hold_seq;
        rsp_if.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one request transaction, idling first at random
  task automatic drive_item(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                            input logic [IO_VALUE_W-1:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= '{mode: mode, key: key, value: value};
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Drop valid and hold until every predicted response has arrived
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Mostly keys in a few clustered slots so that tests hit; the depth is a power of two
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    int unsigned      s;
    k = $urandom();
    if ($urandom_range(99) < 20) return k;
    s = $urandom_range(1) ? $urandom_range(0, 47) :
                            $urandom_range(TABLE_DEPTH - 24, TABLE_DEPTH - 1);
    return (k & ~KEY_W'(TABLE_DEPTH - 1)) | KEY_W'(s);
  endfunction

  function automatic logic [IO_VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 30) return $urandom();
    return value_pool[$urandom_range(15)];
  endfunction

  initial begin
    int  n;
    int  r;
    int  burst;
    bit  held;
    bit  paused;
    sb = new();
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    rst          <= 1'b1;
    rx_idle_pct  <= 51;
    rx_hold_seq  <= 0;
    tx_idle_pct  = 19;
    foreach (value_pool[i]) begin
      value_pool[i] = $urandom();
      if (value_pool[i] == '0) value_pool[i] = 1;
    end
    value_pool[0] = '1;
    value_pool[1] = 1;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table corners
    drive_item(OP_HAS_VALUE, 32'h0000_0000, 32'h0000_0000);
    drive_item(OP_SCAN_NEXT, 32'h0000_0000, 32'h0000_0000);
    drive_item(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Fill the end slots; occupied and zero adds are refused
    drive_item(OP_ADD, 32'h0000_0000, 32'h0000_0001);
    drive_item(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drive_item(OP_ADD, 32'h7FFF_FFFF, 32'h0000_0005);
    drive_item(OP_ADD, 32'h8000_0000, 32'h0000_0009);
    drive_item(OP_ADD, 32'h0000_0005, 32'h0000_0000);
    drive_item(OP_ADD, 32'h0000_0407, 32'hAAAA_5555);
    // Key tests and value searches
    drive_item(OP_HAS_KEY, 32'h0000_0007, 32'h0000_0000);
    drive_item(OP_HAS_KEY, 32'hFFFF_FC00, 32'hFFFF_FFFF);
    drive_item(OP_HAS_KEY, 32'h0000_0005, 32'h0000_0000);
    drive_item(OP_HAS_VALUE, 32'h0000_0000, 32'hFFFF_FFFF);
    drive_item(OP_HAS_VALUE, 32'h0000_0000, 32'h0000_0000);
    drive_item(OP_HAS_VALUE, 32'h0000_0000, 32'h1234_5678);
    // Scan through to exhaustion and beyond
    drive_item(OP_SCAN_START, 32'h0000_0000, 32'h0000_0000);
    repeat (5) drive_item(OP_SCAN_NEXT, 32'h0000_0000, 32'h0000_0000);
    // Change the table in the middle of a scan, then clear under it
    drive_item(OP_SCAN_START, 32'h0000_0000, 32'h0000_0000);
    drive_item(OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
    drive_item(OP_SCAN_NEXT, 32'h0000_0000, 32'h0000_0000);
    drive_item(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drive_item(OP_SCAN_NEXT, 32'h0000_0000, 32'h0000_0000);
    drive_item(OP_REMOVE, 32'h0000_0007, 32'h0000_0000);
    drive_item(OP_ADD, 32'h8000_0000, 32'h0000_0055);
    wait_drained();

    // Random: mostly adds and lookups on clustered keys, with scan bursts
    n      = 0;
    held   = 1'b0;
    paused = 1'b0;
    while (n < RANDOM_ITEMS) begin
      if (n == RANDOM_ITEMS / 3) begin
        tx_idle_pct = 51;
        rx_idle_pct <= 19;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      // hold off the receiver while requests keep coming
      if (!held && n >= 250) begin
        held = 1'b1;
        rx_hold_seq <= rx_hold_seq + 1;
      end
      // pause the sender until the block drains
      if (!paused && n >= 500) begin
        paused = 1'b1;
        wait_drained();
      end
      r = $urandom_range(999);
      if (r < 300) drive_item(OP_ADD, pick_key(), pick_value());
      else if (r < 430) drive_item(OP_REMOVE, pick_key(), $urandom());
      else if (r < 560) drive_item(OP_HAS_KEY, pick_key(), $urandom());
      else if (r < 640) drive_item(OP_HAS_VALUE, $urandom(), pick_value());
      else if (r < 652) drive_item(OP_CLEAR, $urandom(), $urandom());
      else if (r < 662) drive_item(MODE_UNUSED, $urandom(), $urandom());
      else if (r < 690) drive_item(OP_SCAN_START, $urandom(), $urandom());
      else if (r < 900) drive_item(OP_SCAN_NEXT, $urandom(), $urandom());
      else begin
        burst = $urandom_range(1, 12);
        drive_item(OP_SCAN_START, $urandom(), $urandom());
        repeat (burst) drive_item(OP_SCAN_NEXT, $urandom(), $urandom());
        n += burst;
      end
      n++;
    end

    // Drain, then watch for stray responses
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/dmkt_pkg.sv
design/dmkt_if.sv
design/dmkt_ram.sv
design/dmkt_ctrl.sv
design/dmkt_datapath.sv
design/direct_mapped_key_table_core.sv
dv/tb.sv
